FILE: rtl/hlsrgb_pkg.sv
// Shared constants and types for the HLS to RGB converter.
// Used by every module of the block but the queue; depends on nothing else.
package hlsrgb_pkg;

  localparam int unsigned HUE_FRAC_BITS_DEF = 4;
  localparam int unsigned QUEUE_DEPTH_DEF   = 4;

  localparam int unsigned HUE_W   = 14;
  localparam int unsigned LVL_W   = 13;
  localparam int unsigned CH_W    = 16;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned Q12_ONE  = 4096;
  localparam int unsigned Q12_HALF = 2048;
  localparam int unsigned Q12_SH   = 12;
  localparam int unsigned Q24_W    = 25;
  localparam int unsigned Q24_SH   = 24;
  localparam int unsigned D255_W   = 33;

  localparam int unsigned DEG60  = 60;
  localparam int unsigned DEG120 = 120;
  localparam int unsigned DEG180 = 180;
  localparam int unsigned DEG240 = 240;
  localparam int unsigned DEG360 = 360;
  localparam int unsigned CODE_MAX = 255;

  localparam int unsigned Y_W        = 12;
  localparam int unsigned DIV15_MUL  = 17477;
  localparam int unsigned DIV15_SH   = 18;
  localparam int unsigned DIV15_MW   = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIGHT = 2'd0,
    REG_SAT   = 2'd1
  } cfg_reg_t;

endpackage

FILE: rtl/hls_to_rgb_converter.sv
// HLS to RGB converter top level: configuration registers, front end, queue
// and back end. Depends on hlsrgb_pkg and all hlsrgb_* modules.
//
// Each input beat on in_valid/in_ready carries one hue in units of
// 1/2^HUE_FRAC_BITS degree; each output beat on out_valid/out_ready carries
// the red, green and blue intensities for it, in the order the hues came in.
// Lightness and saturation are set through the cfg_ write port (index 0 and
// 1, Q12 values); the user must do so only while no beat is in flight, as
// the block does not enforce it. Other indexes are ignored. Throughput is
// one beat per cycle while the receiver keeps out_ready high. Each hue
// passes through three front stages (quotient estimate, turn reduction,
// classification into the queue), the queue, three back stages (ramp
// product, rounding shift, divide by fifteen) and the output register.
// Reset loads lightness 0.5 and saturation 1.0 and empties the pipeline and
// queue; in_ready rises in the cycle after reset is released.
// When the receiver stalls, the back stages fill, then the queue of
// QUEUE_DEPTH beats, then the front stages, and only then in_ready drops.
module hls_to_rgb_converter #(
  parameter int unsigned HUE_FRAC_BITS = hlsrgb_pkg::HUE_FRAC_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH   = hlsrgb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [hlsrgb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hlsrgb_pkg::LVL_W-1:0]     cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [hlsrgb_pkg::HUE_W-1:0]     in_hue_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [hlsrgb_pkg::CH_W-1:0]      out_red_out,
  output logic [hlsrgb_pkg::CH_W-1:0]      out_green_out,
  output logic [hlsrgb_pkg::CH_W-1:0]      out_blue_out
);
  import hlsrgb_pkg::*;

  localparam int unsigned WW    = $clog2((DEG60 << HUE_FRAC_BITS) + 1);
  localparam int unsigned ACC_W = D255_W + WW;

  logic [D255_W-1:0] d255;
  logic [ACC_W-1:0]  base255;
  logic              q_full, q_push, q_pop, head_valid;
  logic [3*WW-1:0]   q_entry, head_entry;

  hlsrgb_cfg #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .d255      (d255),
    .base255   (base255)
  );

  hlsrgb_front #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .hue      (in_hue_in),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  hlsrgb_fifo #(.WIDTH(3 * WW), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .wr_data    (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .rd_data    (head_entry)
  );

  hlsrgb_back #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .q_pop      (q_pop),
    .d255       (d255),
    .base255    (base255),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .red        (out_red_out),
    .green      (out_green_out),
    .blue       (out_blue_out)
  );

endmodule

FILE: rtl/hlsrgb_cfg.sv
// Configuration registers and the per-configuration terms derived from them.
// Depends on hlsrgb_pkg.
module hlsrgb_cfg #(
  parameter int unsigned HUE_FRAC_BITS = hlsrgb_pkg::HUE_FRAC_BITS_DEF,
  localparam int unsigned WW = $clog2((hlsrgb_pkg::DEG60 << HUE_FRAC_BITS) + 1),
  localparam int unsigned ACC_W = hlsrgb_pkg::D255_W + WW
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [hlsrgb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hlsrgb_pkg::LVL_W-1:0]     cfg_data,
  output logic [hlsrgb_pkg::D255_W-1:0]    d255,
  output logic [ACC_W-1:0]                 base255
);
  import hlsrgb_pkg::*;

  localparam int unsigned H60 = DEG60 << HUE_FRAC_BITS;
  localparam int unsigned M255 = CODE_MAX * H60;

  logic [LVL_W-1:0] light_r, sat_r;
  logic [LVL_W-1:0] lc, sc;
  logic [LVL_W-1:0] l1_r, s1_r, l2_r;
  logic [Q24_W-1:0] ls_r, m2q_r, m1q_r, d_r;
  logic [Q24_W:0]   m2q_nxt, lsh13;
  logic [ACC_W-1:0] bm_r, base255_r;
  logic [D255_W-1:0] d255_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_r <= LVL_W'(Q12_HALF);
      sat_r   <= LVL_W'(Q12_ONE);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_LIGHT: light_r <= cfg_data;
        REG_SAT:   sat_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    lc = (light_r > LVL_W'(Q12_ONE)) ? LVL_W'(Q12_ONE) : light_r;
    sc = (sat_r > LVL_W'(Q12_ONE)) ? LVL_W'(Q12_ONE) : sat_r;
    if (l1_r <= LVL_W'(Q12_HALF)) begin
      m2q_nxt = (Q24_W + 1)'(ls_r) + ((Q24_W + 1)'(l1_r) << Q12_SH);
    end else begin
      m2q_nxt = (((Q24_W + 1)'(l1_r) + (Q24_W + 1)'(s1_r)) << Q12_SH) - (Q24_W + 1)'(ls_r);
    end
    lsh13 = (Q24_W + 1)'(l2_r) << (Q12_SH + 1);
  end

  always_ff @(posedge clk) begin
    l1_r      <= lc;
    s1_r      <= sc;
    ls_r      <= Q24_W'(lc * sc);
    m2q_r     <= Q24_W'(m2q_nxt);
    l2_r      <= l1_r;
    m1q_r     <= Q24_W'(lsh13 - (Q24_W + 1)'(m2q_r));
    d_r       <= Q24_W'(((Q24_W + 1)'(m2q_r) << 1) - lsh13);
    d255_r    <= (D255_W'(d_r) << 8) - D255_W'(d_r);
    bm_r      <= ACC_W'(m1q_r) * ACC_W'(M255);
    base255_r <= bm_r + (ACC_W'(H60) << (Q24_SH - 1));
  end

  assign d255    = d255_r;
  assign base255 = base255_r;

endmodule

FILE: rtl/hlsrgb_front.sv
// Front end: accepts hue beats, reduces them to one turn and classifies the
// ramp position of each channel. Depends on hlsrgb_pkg.
module hlsrgb_front #(
  parameter int unsigned HUE_FRAC_BITS = hlsrgb_pkg::HUE_FRAC_BITS_DEF,
  localparam int unsigned WW = $clog2((hlsrgb_pkg::DEG60 << HUE_FRAC_BITS) + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [hlsrgb_pkg::HUE_W-1:0] hue,
  input  logic                         q_full,
  output logic                         q_push,
  output logic [3*WW-1:0]              q_entry
);
  import hlsrgb_pkg::*;

  localparam int unsigned H60  = DEG60 << HUE_FRAC_BITS;
  localparam int unsigned H120 = DEG120 << HUE_FRAC_BITS;
  localparam int unsigned H180 = DEG180 << HUE_FRAC_BITS;
  localparam int unsigned H240 = DEG240 << HUE_FRAC_BITS;
  localparam int unsigned H360 = DEG360 << HUE_FRAC_BITS;
  localparam int unsigned H_W  = $clog2(H360);
  localparam int unsigned RSH  = 24;
  localparam int unsigned RECIP = (1 << RSH) / H360;
  localparam int unsigned PROD_W = HUE_W + RSH;
  localparam int unsigned QMAX = ((1 << HUE_W) - 1) / H360;
  localparam int unsigned Q_W  = (QMAX > 0) ? $clog2(QMAX + 1) : 1;
  localparam int unsigned CW   = ((HUE_W > H_W) ? HUE_W : H_W) + 1;

  logic run_r, v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3, acc;
  logic [HUE_W-1:0]  x1_r, x2_r, qd_r, diff;
  logic [Q_W-1:0]    q_r, q_nxt;
  logic [PROD_W-1:0] prod;
  logic [CW-1:0]     dext;
  logic [H_W-1:0]    h0_r, h0_nxt;

  function automatic logic [H_W-1:0] wrap_add(input logic [H_W-1:0] h,
                                               input logic [H_W:0] off);
    logic [H_W:0] s;
    s = {1'b0, h} + off;
    return (s >= (H_W + 1)'(H360)) ? H_W'(s - (H_W + 1)'(H360)) : H_W'(s);
  endfunction

  function automatic logic [WW-1:0] ramp(input logic [H_W-1:0] h);
    logic [WW-1:0] w;
    if (h < H_W'(H60)) begin
      w = WW'(h);
    end else if (h < H_W'(H180)) begin
      w = WW'(H60);
    end else if (h < H_W'(H240)) begin
      w = WW'(H_W'(H240) - h);
    end else begin
      w = '0;
    end
    return w;
  endfunction

  assign rdy3     = !v3_r || !q_full;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = run_r && rdy1;
  assign acc      = in_valid && in_ready;
  assign q_push   = v3_r && !q_full;

  always_comb begin
    prod   = PROD_W'(hue) * PROD_W'(RECIP);
    q_nxt  = Q_W'(prod >> RSH);
    diff   = x2_r - qd_r;
    dext   = CW'(diff);
    h0_nxt = (dext >= CW'(H360)) ? H_W'(dext - CW'(H360)) : H_W'(dext);
    q_entry = {ramp(wrap_add(h0_r, (H_W + 1)'(H120))),
               ramp(h0_r),
               ramp(wrap_add(h0_r, (H_W + 1)'(H240)))};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
    end else begin
      run_r <= 1'b1;
      if (rdy1) v1_r <= acc;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      x1_r <= hue;
      q_r  <= q_nxt;
    end
    if (rdy2) begin
      x2_r <= x1_r;
      qd_r <= HUE_W'(q_r * H360);
    end
    if (rdy3) begin
      h0_r <= h0_nxt;
    end
  end

endmodule

FILE: rtl/hlsrgb_fifo.sv
// Short queue of classified beats between the front and back ends.
// Depends on no package.
module hlsrgb_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] rd_data
);
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [WIDTH-1:0] rd_data_r;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign rd_data    = rd_data_r;
  assign rd_ptr_nxt = !pop ? rd_ptr_r :
                      (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // The head is kept in a register; a beat written into an empty queue
  // goes straight to it.
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wr_data;
    if (push && (wr_ptr_r == rd_ptr_nxt)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_ptr_nxt];
    end
  end

endmodule

FILE: rtl/hlsrgb_back.sv
// Back end: evaluates the channel values from the ramp positions, rounds
// them to 8-bit codes and drives the result register. Depends on hlsrgb_pkg.
module hlsrgb_back #(
  parameter int unsigned HUE_FRAC_BITS = hlsrgb_pkg::HUE_FRAC_BITS_DEF,
  localparam int unsigned WW = $clog2((hlsrgb_pkg::DEG60 << HUE_FRAC_BITS) + 1),
  localparam int unsigned ACC_W = hlsrgb_pkg::D255_W + WW
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          head_valid,
  input  logic [3*WW-1:0]               head_entry,
  output logic                          q_pop,
  input  logic [hlsrgb_pkg::D255_W-1:0] d255,
  input  logic [ACC_W-1:0]              base255,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hlsrgb_pkg::CH_W-1:0]   red,
  output logic [hlsrgb_pkg::CH_W-1:0]   green,
  output logic [hlsrgb_pkg::CH_W-1:0]   blue
);
  import hlsrgb_pkg::*;

  localparam int unsigned YSH = Q24_SH + HUE_FRAC_BITS + 2;
  localparam int unsigned MW  = Y_W + DIV15_MW;

  logic v1_r, v2_r, v3_r, ov_r;
  logic rdy1, rdy2, rdy3, rdy_o, white;
  logic [2:0][WW-1:0]     w;
  logic [2:0][ACC_W-1:0]  dw_r;
  logic [2:0][Y_W-1:0]    y_r;
  logic [2:0][CODE_W-1:0] code_r;
  logic [CH_W-1:0] red_r, green_r, blue_r;

  assign rdy_o = !ov_r || out_ready;
  assign rdy3  = !v3_r || rdy_o;
  assign rdy2  = !v2_r || rdy3;
  assign rdy1  = !v1_r || rdy2;
  assign q_pop = head_valid && rdy1;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      w[c] = head_entry[c*WW +: WW];
    end
    white = (code_r[0] == '0) && (code_r[1] == '0) && (code_r[2] == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (rdy1)  v1_r <= head_valid;
      if (rdy2)  v2_r <= v1_r;
      if (rdy3)  v3_r <= v2_r;
      if (rdy_o) ov_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (rdy1) dw_r[c] <= ACC_W'(d255) * ACC_W'(w[c]);
      if (rdy2) y_r[c] <= Y_W'((base255 + dw_r[c]) >> YSH);
      if (rdy3) code_r[c] <= CODE_W'((MW'(y_r[c]) * MW'(DIV15_MUL)) >> DIV15_SH);
    end
    if (rdy_o) begin
      red_r   <= white ? '1 : {code_r[2], code_r[2]};
      green_r <= white ? '1 : {code_r[1], code_r[1]};
      blue_r  <= white ? '1 : {code_r[0], code_r[0]};
    end
  end

  assign out_valid = ov_r;
  assign red       = red_r;
  assign green     = green_r;
  assign blue      = blue_r;

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for hls_to_rgb_converter: hues go in, RGB beats come out.
// It predicts each beat from the lightness and saturation settings it has written.
// Depends on hlsrgb_pkg and the converter RTL only.
`timescale 1ns / 100ps

module tb_top;
  import hlsrgb_pkg::*;

  localparam longint HUE_60   = longint'(DEG60) << HUE_FRAC_BITS_DEF;
  localparam longint HUE_120  = longint'(DEG120) << HUE_FRAC_BITS_DEF;
  localparam longint HUE_180  = longint'(DEG180) << HUE_FRAC_BITS_DEF;
  localparam longint HUE_240  = longint'(DEG240) << HUE_FRAC_BITS_DEF;
  localparam longint HUE_360  = longint'(DEG360) << HUE_FRAC_BITS_DEF;
  localparam longint LVL_ONE  = Q12_ONE;
  localparam longint LVL_HALF = Q12_HALF;
  localparam longint CODE_TOP = CODE_MAX;

  localparam int unsigned HUE_TOP_IN  = 11519;
  localparam int unsigned LVL_ALL     = (1 << LVL_W) - 1;
  localparam int unsigned HUE_ALL     = (1 << HUE_W) - 1;
  localparam int unsigned RAND_PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 104;
  localparam int unsigned SETTLE_CYCLES  = 10;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PRINT_LIMIT    = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FREE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FREE_HI = 2'd3;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LVL_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [HUE_W-1:0]     in_hue_in;
  logic                 out_valid;
  logic                 out_ready;
  logic [CH_W-1:0]      out_red_out;
  logic [CH_W-1:0]      out_green_out;
  logic [CH_W-1:0]      out_blue_out;

  rgb_t             pending_rgb[$];
  logic [LVL_W-1:0] light_cur;
  logic [LVL_W-1:0] sat_cur;
  bit               steady;
  int unsigned      mismatches;
  int unsigned      hues_sent;
  int unsigned      beats_checked;
  int unsigned      settings_used;
  int unsigned      idle_cycles;

  hls_to_rgb_converter i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_hue_in    (in_hue_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_red_out  (out_red_out),
    .out_green_out(out_green_out),
    .out_blue_out (out_blue_out)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [CODE_W-1:0] ramp_code(input longint m1, input longint m2,
                                                  input longint h);
    longint w;
    longint num;
    longint code;
    if (h < HUE_60) begin
      w = h;
    end else if (h < HUE_180) begin
      w = HUE_60;
    end else if (h < HUE_240) begin
      w = HUE_240 - h;
    end else begin
      w = 0;
    end
    num = m1 * HUE_60 + (m2 - m1) * w;
    if (num < 0) begin
      num = 0;
    end
    code = (CODE_TOP * num + (longint'(1) << (Q24_SH - 1)) * HUE_60)
           / ((longint'(1) << Q24_SH) * HUE_60);
    if (code > CODE_TOP) begin
      code = CODE_TOP;
    end
    return code[CODE_W-1:0];
  endfunction

  function automatic rgb_t convert_hue(input logic [HUE_W-1:0] hue);
    longint l;
    longint s;
    longint m1;
    longint m2;
    longint h0;
    logic [CODE_W-1:0] r;
    logic [CODE_W-1:0] g;
    logic [CODE_W-1:0] b;
    rgb_t res;
    l = light_cur;
    s = sat_cur;
    if (l > LVL_ONE) begin
      l = LVL_ONE;
    end
    if (s > LVL_ONE) begin
      s = LVL_ONE;
    end
    if (l <= LVL_HALF) begin
      m2 = l * (s + LVL_ONE);
    end else begin
      m2 = (l + s) * LVL_ONE - l * s;
    end
    m1 = 2 * l * LVL_ONE - m2;
    h0 = longint'(hue) % HUE_360;
    r = ramp_code(m1, m2, (h0 + HUE_120) % HUE_360);
    g = ramp_code(m1, m2, h0);
    b = ramp_code(m1, m2, (h0 + HUE_360 - HUE_120) % HUE_360);
    if (r == 0 && g == 0 && b == 0) begin
      res.red   = '1;
      res.green = '1;
      res.blue  = '1;
    end else begin
      res.red   = r * 16'd257;
      res.green = g * 16'd257;
      res.blue  = b * 16'd257;
    end
    return res;
  endfunction

  function automatic int unsigned idle_len();
    if ($urandom_range(0, 9) < 8) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [HUE_W-1:0] pick_hue();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 8) begin
      return HUE_W'($urandom_range(0, HUE_TOP_IN));
    end
    if (sel == 8) begin
      return HUE_W'($urandom_range(1, 11) * HUE_60 + $urandom_range(0, 2) - 1);
    end
    return HUE_W'($urandom_range(0, HUE_ALL));
  endfunction

  function automatic logic [LVL_W-1:0] pick_level();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 3) begin
      return '0;
    end
    if (sel < 6) begin
      return LVL_W'(Q12_ONE);
    end
    if (sel < 8) begin
      return LVL_W'($urandom_range(Q12_ONE + 1, LVL_ALL));
    end
    return LVL_W'($urandom_range(0, Q12_ONE));
  endfunction

  task automatic report_mismatch(input string what, input logic [CH_W-1:0] want,
                                 input logic [CH_W-1:0] got);
    if (mismatches < PRINT_LIMIT) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
    mismatches++;
  endtask

  // The sender keeps valid high across back-to-back beats.
  task automatic send_hue(input logic [HUE_W-1:0] hue);
    int unsigned gap;
    gap = 0;
    if (!steady && $urandom_range(0, 1) == 1) begin
      gap = idle_len();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_hue_in <= hue;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_rgb.push_back(convert_hue(hue));
    hues_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LVL_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == REG_LIGHT) begin
      light_cur = val;
    end else if (idx == REG_SAT) begin
      sat_cur = val;
    end
  endtask

  task automatic set_levels(input logic [LVL_W-1:0] light, input logic [LVL_W-1:0] sat);
    drain_results();
    write_reg(REG_LIGHT, light);
    write_reg(REG_SAT, sat);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  task automatic test_reset_levels();
    send_hue('0);
    send_hue(HUE_W'(1));
    send_hue(HUE_W'(HUE_60 - 1));
    send_hue(HUE_W'(HUE_60));
    send_hue(HUE_W'(HUE_120));
    send_hue(HUE_W'(HUE_180));
    send_hue(HUE_W'(HUE_240));
    send_hue(HUE_W'(HUE_360 - 1));
    send_hue(HUE_W'(HUE_360));
    send_hue(HUE_W'(HUE_TOP_IN));
    send_hue(HUE_W'(HUE_ALL));
  endtask

  task automatic test_level_extremes();
    set_levels('0, LVL_W'(Q12_ONE));
    send_hue(HUE_W'(HUE_60));
    send_hue(HUE_W'(HUE_240 + 5));
    set_levels(LVL_W'(Q12_ONE), '0);
    send_hue('0);
    send_hue(HUE_W'(HUE_180 + 7));
    set_levels(LVL_W'(LVL_ALL), LVL_W'(LVL_ALL));
    send_hue(HUE_W'(HUE_120 + 3));
    send_hue(HUE_W'(HUE_ALL));
    set_levels(LVL_W'(Q12_HALF), '0);
    send_hue(HUE_W'(333));
    send_hue(HUE_W'(HUE_360 + HUE_60));
    set_levels(LVL_W'(3072), LVL_W'(2500));
    send_hue(HUE_W'(HUE_60 / 2));
    send_hue(HUE_W'(HUE_240 - 1));
  endtask

  // Writes to unused indexes must leave both levels untouched.
  task automatic test_spare_index();
    drain_results();
    write_reg(CFG_IDX_FREE_LO, '0);
    write_reg(CFG_IDX_FREE_HI, LVL_W'(LVL_ALL));
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    send_hue(HUE_W'(HUE_60 + 11));
    send_hue(HUE_W'(HUE_180 + 200));
  endtask

  task automatic test_random_hues();
    for (int unsigned p = 0; p < RAND_PHASES; p++) begin
      if ($urandom_range(0, 4) == 0) begin
        drain_results();
        write_reg($urandom_range(0, 1) ? CFG_IDX_FREE_LO : CFG_IDX_FREE_HI,
                  LVL_W'($urandom_range(0, LVL_ALL)));
        cfg_wr_en <= 1'b0;
        @(posedge clk);
      end
      set_levels(pick_level(), pick_level());
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 40 == 0) begin
          steady = ($urandom_range(0, 3) == 0);
        end
        send_hue(pick_hue());
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (!steady && $urandom_range(0, 99) < 20) begin
        out_ready <= 1'b0;
        stall_left = idle_len() - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    rgb_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_rgb.size() == 0) begin
        report_mismatch("unexpected beat red", '0, out_red_out);
      end else begin
        want = pending_rgb.pop_front();
        if (out_red_out !== want.red) begin
          report_mismatch("red_out", want.red, out_red_out);
        end
        if (out_green_out !== want.green) begin
          report_mismatch("green_out", want.green, out_green_out);
        end
        if (out_blue_out !== want.blue) begin
          report_mismatch("blue_out", want.blue, out_blue_out);
        end
        beats_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_hue_in     = '0;
    light_cur     = LVL_W'(Q12_HALF);
    sat_cur       = LVL_W'(Q12_ONE);
    steady        = 1'b0;
    mismatches    = 0;
    hues_sent     = 0;
    beats_checked = 0;
    settings_used = 1;
    idle_cycles   = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_levels();
    test_level_extremes();
    test_spare_index();
    test_random_hues();
    drain_results();
    if (pending_rgb.size() != 0) begin
      report_mismatch("missing beats", '0, CH_W'(pending_rgb.size()));
    end
    $display("Sent %0d hues under %0d lightness and saturation settings, with stalls on both sides.",
             hues_sent, settings_used);
    $display("Checked %0d RGB beats and found %0d mismatches.", beats_checked, mismatches);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/hlsrgb_pkg.sv
rtl/hlsrgb_cfg.sv
rtl/hlsrgb_front.sv
rtl/hlsrgb_fifo.sv
rtl/hlsrgb_back.sv
rtl/hls_to_rgb_converter.sv
dv/tb_top.sv
